/* src/pdtu_pkg.sv */
`default_nettype none

package pdtu_pkg;

    localparam logic [47:0] DRAM_BASE        = 48'h0000_8000_0000;
    localparam logic [47:0] STACK_BASE_RESET = 48'h000A_0000_0000;
    localparam logic [11:0] DESC_RESET_ATTRS = 12'h727;
    localparam int          AF_BIT           = 10;
    localparam int          AP_LSB           = 6;
    localparam int          PAGE_SHIFT       = 12;

    typedef enum logic [1:0] {
        REQ_SET_FLAG = 2'd0,
        REQ_SET_PERM = 2'd1,
        REQ_SET_MAP  = 2'd2,
        REQ_READ_MAP = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BELOW      = 2'd1,
        STATUS_BEYOND     = 2'd2,
        STATUS_FLAG_STACK = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_WRITE,
        ST_SHADOW_READ,
        ST_SHADOW_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic check;
        logic rd_main;
        logic wr_main;
        logic rd_shadow;
        logic wr_shadow;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic fail;
        logic stack_write;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

/* src/pdtu_ctrl.sv */
`default_nettype none

module pdtu_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire pdtu_pkg::dp_stat_t   stat,
    output pdtu_pkg::ctrl_cmd_t       cmd
);
    import pdtu_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (stat.clear_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK:        state_next = ST_READ;
            ST_READ:         state_next = stat.fail ? ST_DONE : ST_WRITE;
            ST_WRITE:        state_next = stat.stack_write ? ST_SHADOW_READ : ST_DONE;
            ST_SHADOW_READ:  state_next = ST_SHADOW_WRITE;
            ST_SHADOW_WRITE: state_next = ST_DONE;
            ST_DONE: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default:         state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:        cmd.clear_step = 1'b1;
            ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.load_req = s_tvalid;
            end
            ST_CHECK:        cmd.check     = 1'b1;
            ST_READ:         cmd.rd_main   = !stat.fail;
            ST_WRITE:        cmd.wr_main   = 1'b1;
            ST_SHADOW_READ:  cmd.rd_shadow = 1'b1;
            ST_SHADOW_WRITE: cmd.wr_shadow = 1'b1;
            ST_DONE:         cmd.load_out  = stat.out_free;
            default:         cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/pdtu_datapath.sv */
`default_nettype none

module pdtu_datapath #(
    parameter int DRAM_PAGES  = 4096,
    parameter int STACK_PAGES = 512
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pdtu_pkg::ctrl_cmd_t  cmd,
    output pdtu_pkg::dp_stat_t        stat,
    input  wire logic [2:0]           s_tuser,
    input  wire logic [103:0]         s_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [47:0]          cfg_wdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [1:0]                m_tuser,
    output logic [47:0]               m_tdata
);
    import pdtu_pkg::*;

    localparam int DW        = $clog2(DRAM_PAGES);
    localparam int SW        = $clog2(STACK_PAGES);
    localparam int CLEAR_LEN = (DRAM_PAGES > STACK_PAGES) ? DRAM_PAGES : STACK_PAGES;
    localparam int CW        = $clog2(CLEAR_LEN);

    localparam logic [63:0]   DRAM_LIMIT = 64'(DRAM_BASE) + 64'(DRAM_PAGES) * 64'h1000;
    localparam logic [48:0]   HALF_SPAN  = 49'(STACK_PAGES / 2) * 49'h1000;
    localparam logic [48:0]   FULL_SPAN  = 49'(STACK_PAGES) * 49'h1000;
    localparam logic [SW-1:0] HALF_IDX   = SW'(STACK_PAGES / 2);

    function automatic logic [63:0] modify_desc(
        input logic [63:0] d,
        input req_type_t   kind,
        input logic        flag,
        input logic [1:0]  perm,
        input logic [47:0] pa
    );
        logic [63:0] r;
        r = d;
        unique case (kind)
            REQ_SET_FLAG: r[AF_BIT] = flag;
            REQ_SET_PERM: r[AP_LSB +: 2] = perm;
            REQ_SET_MAP:  r[47:PAGE_SHIFT] = pa[47:PAGE_SHIFT];
            REQ_READ_MAP: r = d;
            default:      r = d;
        endcase
        return r;
    endfunction

    // configuration and derived stack limits
    logic [47:0] base_reg;
    logic [48:0] lim_half_reg;
    logic [48:0] lim_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= STACK_BASE_RESET;
            lim_half_reg <= {1'b0, STACK_BASE_RESET} + HALF_SPAN;
            lim_full_reg <= {1'b0, STACK_BASE_RESET} + FULL_SPAN;
        end else if (cfg_we) begin
            base_reg     <= cfg_wdata;
            lim_half_reg <= {1'b0, cfg_wdata} + HALF_SPAN;
            lim_full_reg <= {1'b0, cfg_wdata} + FULL_SPAN;
        end
    end

    // clearing pass counter
    logic [CW-1:0] clr_cnt_reg;
    logic          clr_dram;
    logic          clr_stack;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step && !stat.clear_done) begin
            clr_cnt_reg <= clr_cnt_reg + CW'(1);
        end
    end

    assign clr_dram  = cmd.clear_step && (32'(clr_cnt_reg) < DRAM_PAGES);
    assign clr_stack = cmd.clear_step && (32'(clr_cnt_reg) < STACK_PAGES);

    // request capture
    req_type_t   type_reg;
    logic        region_reg;
    logic [47:0] va_reg;
    logic        flag_reg;
    logic [1:0]  perm_reg;
    logic [47:0] pa_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            type_reg   <= req_type_t'(s_tuser[1:0]);
            region_reg <= s_tuser[2];
            va_reg     <= s_tdata[47:0];
            flag_reg   <= s_tdata[48];
            perm_reg   <= s_tdata[50:49];
            pa_reg     <= s_tdata[98:51];
        end
    end

    // range check and index
    status_t       status_next;
    status_t       status_reg;
    logic [47:0]   dram_off;
    logic [47:0]   stack_off;
    logic [48:0]   stack_lim;
    logic [DW-1:0] dram_idx_reg;
    logic [SW-1:0] stack_idx_reg;

    assign dram_off  = va_reg - DRAM_BASE;
    assign stack_off = va_reg - base_reg;
    assign stack_lim = (type_reg == REQ_READ_MAP) ? lim_full_reg : lim_half_reg;

    always_comb begin
        priority if (!region_reg) begin
            priority if (va_reg < DRAM_BASE)              status_next = STATUS_BELOW;
            else if ({16'b0, va_reg} >= DRAM_LIMIT)      status_next = STATUS_BEYOND;
            else                                         status_next = STATUS_OK;
        end else begin
            priority if (type_reg == REQ_SET_FLAG)       status_next = STATUS_FLAG_STACK;
            else if (va_reg < base_reg)                  status_next = STATUS_BELOW;
            else if ({1'b0, va_reg} >= stack_lim)        status_next = STATUS_BEYOND;
            else                                         status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.check) begin
            status_reg    <= status_next;
            dram_idx_reg  <= dram_off[PAGE_SHIFT +: DW];
            stack_idx_reg <= stack_off[PAGE_SHIFT +: SW];
        end
    end

    // descriptor memories
    logic [63:0]   dram_mem [DRAM_PAGES];
    logic [63:0]   stack_mem [STACK_PAGES];
    logic [63:0]   dram_q_reg;
    logic [63:0]   stack_q_reg;
    logic          dram_we;
    logic          stack_we;
    logic [DW-1:0] dram_waddr;
    logic [SW-1:0] stack_waddr;
    logic [SW-1:0] stack_raddr;
    logic [SW-1:0] shadow_idx;
    logic [63:0]   dram_wdata;
    logic [63:0]   stack_wdata;
    logic [63:0]   dram_init;
    logic [63:0]   stack_init;

    assign shadow_idx  = stack_idx_reg + HALF_IDX;
    assign dram_init   = {16'b0, DRAM_BASE[47:PAGE_SHIFT] + 36'(clr_cnt_reg), DESC_RESET_ATTRS};
    assign stack_init  = {16'b0, STACK_BASE_RESET[47:PAGE_SHIFT] + 36'(clr_cnt_reg),
                          DESC_RESET_ATTRS};

    assign dram_we     = clr_dram || (cmd.wr_main && !region_reg);
    assign stack_we    = clr_stack || ((cmd.wr_main || cmd.wr_shadow) && region_reg);
    assign dram_waddr  = cmd.clear_step ? clr_cnt_reg[DW-1:0] : dram_idx_reg;
    assign stack_waddr = cmd.clear_step ? clr_cnt_reg[SW-1:0]
                       : (cmd.wr_shadow ? shadow_idx : stack_idx_reg);
    assign stack_raddr = cmd.rd_shadow ? shadow_idx : stack_idx_reg;
    assign dram_wdata  = cmd.clear_step ? dram_init
                       : modify_desc(dram_q_reg, type_reg, flag_reg, perm_reg, pa_reg);
    assign stack_wdata = cmd.clear_step ? stack_init
                       : modify_desc(stack_q_reg, type_reg, flag_reg, perm_reg, pa_reg);

    always_ff @(posedge aclk) begin
        if (dram_we) begin
            dram_mem[dram_waddr] <= dram_wdata;
        end
        if (cmd.rd_main && !region_reg) begin
            dram_q_reg <= dram_mem[dram_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if ((cmd.rd_main || cmd.rd_shadow) && region_reg) begin
            stack_q_reg <= stack_mem[stack_raddr];
        end
    end

    // read-back value
    logic [47:0] mapped_reg;
    logic [63:0] main_q;

    assign main_q = region_reg ? stack_q_reg : dram_q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            mapped_reg <= '0;
        end else if (cmd.wr_main && type_reg == REQ_READ_MAP) begin
            mapped_reg <= {main_q[47:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        end
    end

    // output register
    logic        m_tvalid_reg;
    logic [1:0]  m_status_reg;
    logic [47:0] m_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_status_reg <= status_reg;
            m_addr_reg   <= mapped_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = m_addr_reg;

    assign stat.clear_done  = (32'(clr_cnt_reg) == CLEAR_LEN - 1);
    assign stat.fail        = (status_reg != STATUS_OK);
    assign stat.stack_write = region_reg && (type_reg != REQ_READ_MAP);
    assign stat.out_free    = !m_tvalid_reg || m_tready;

endmodule

`default_nettype wire

/* src/page_descriptor_table_update_core.sv */
// sequence: a request is captured, range checked, its entry read and then written back, and
// for a stack write the shadow entry is also read and written; a fault skips these accesses
// throughput: a new transaction is accepted only after the previous result has been loaded
// into the output register, which waits while a pending result has not yet been taken
// reset: synchronous active low; after reset a clearing pass over max(DRAM_PAGES, STACK_PAGES)
// entries writes the identity descriptors while s_tready stays low
`default_nettype none

module page_descriptor_table_update_core #(
    parameter int DRAM_PAGES  = 4096,
    parameter int STACK_PAGES = 512
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [103:0]  s_tdata,   // virt_addr, flag_value, perm_value, phys_addr
    input  wire logic [2:0]    s_tuser,   // req_type, region
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,   // mapped_addr
    output logic [1:0]         m_tuser,   // status
    input  wire logic          cfg_we,
    input  wire logic [47:0]   cfg_wdata
);
    import pdtu_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pdtu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pdtu_datapath #(
        .DRAM_PAGES  (DRAM_PAGES),
        .STACK_PAGES (STACK_PAGES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_step |-> !s_tready)
        else $error("input accepted during clearing pass");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("result overwrites pending output");

    a_one_command: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clear_step, cmd.load_req, cmd.check, cmd.rd_main, cmd.wr_main,
                  cmd.rd_shadow, cmd.wr_shadow, cmd.load_out}))
        else $error("more than one datapath command");

    a_shadow_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_shadow |-> (stat.stack_write && !stat.fail))
        else $error("shadow write on a non-stack or faulted request");

endmodule

`default_nettype wire
